// ===== rtl/core/ab2lp_pkg.sv =====
package ab2lp_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_BUILT    = 3'd0,
    STAT_NO_VCL   = 3'd1,
    STAT_INVALID  = 3'd2,
    STAT_PROTOCOL = 3'd3,
    STAT_NO_SPACE = 3'd4
  } status_e;

  // Control sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DECIDE,
    S_READ,
    S_PUSH,
    S_SUM
  } fsm_e;

  localparam int unsigned IN_W  = 264;
  localparam int unsigned OUT_W = 328;

  localparam logic [4:0]  NAL_TYPE_MASK = 5'h1f;
  localparam logic [4:0]  NAL_VCL_FIRST = 5'd1;
  localparam logic [4:0]  NAL_IDR       = 5'd5;
  localparam logic [4:0]  NAL_SPS       = 5'd7;
  localparam logic [4:0]  NAL_PPS       = 5'd8;
  localparam logic [32:0] LEN_WORD      = 33'd4;
  localparam logic [32:0] TOTAL_MAX     = 33'h1_ffff_ffff;

  // Input item, first field in the lowest bits
  typedef struct packed {
    logic [31:0] generation;
    logic [63:0] pts;
    logic [31:0] out_capacity;
    logic [31:0] au_size;
    logic [39:0] head_bytes;
    logic [31:0] span_len;
    logic [31:0] span_offset;
  } span_item_t;

  // Result item, first field in the lowest bits
  typedef struct packed {
    logic [2:0]  pad;
    logic [31:0] generation_out;
    logic [63:0] pts_out;
    logic [31:0] pps_len;
    logic [31:0] pps_start;
    logic [31:0] sps_len;
    logic [31:0] sps_start;
    logic        key_frame;
    logic [31:0] copy_len;
    logic [31:0] source_offset;
    logic [32:0] byte_position;
    status_e     status;
  } result_t;

  // Parsed span, from the span parser to the sequencer
  typedef struct packed {
    logic        bad;
    logic        vcl;
    logic        idr;
    logic        sps;
    logic        pps;
    logic [31:0] poff;
    logic [31:0] nlen;
  } span_info_t;

endpackage

// ===== rtl/core/ab2lp_span_parse.sv =====
module ab2lp_span_parse
  import ab2lp_pkg::*;
(
  input  logic [31:0] span_offset_i,
  input  logic [31:0] span_len_i,
  input  logic [39:0] head_bytes_i,
  input  logic [31:0] au_size_i,
  output span_info_t  info_o
);

  logic [7:0]  b0, b1, b2, b3, b4;
  logic        four, three;
  logic [2:0]  pre;
  logic [4:0]  nal_type;
  logic [31:0] room;
  logic        bounds_bad;

  // Split the header bytes, first byte on top
  assign b0 = head_bytes_i[39:32];
  assign b1 = head_bytes_i[31:24];
  assign b2 = head_bytes_i[23:16];
  assign b3 = head_bytes_i[15:8];
  assign b4 = head_bytes_i[7:0];

  // Detect the start code, long form first
  assign four  = (span_len_i >= 32'd4) && (b0 == 8'd0) && (b1 == 8'd0) &&
                 (b2 == 8'd0) && (b3 == 8'd1);
  assign three = !four && (span_len_i >= 32'd3) && (b0 == 8'd0) && (b1 == 8'd0) &&
                 (b2 == 8'd1);
  assign pre      = four ? 3'd4 : 3'd3;
  assign nal_type = (four ? b4[4:0] : b3[4:0]) & NAL_TYPE_MASK;

  // Check the span against the unit bounds
  assign room       = au_size_i - span_offset_i;
  assign bounds_bad = (span_len_i == 32'd0) || (span_offset_i > au_size_i) ||
                      (span_len_i > room);

  always_comb begin
    info_o      = '0;
    info_o.bad  = bounds_bad || !(four || three) || (span_len_i <= {29'd0, pre}) ||
                  (nal_type == 5'd0);
    info_o.vcl  = (nal_type >= NAL_VCL_FIRST) && (nal_type <= NAL_IDR);
    info_o.idr  = (nal_type == NAL_IDR);
    info_o.sps  = (nal_type == NAL_SPS);
    info_o.pps  = (nal_type == NAL_PPS);
    info_o.poff = span_offset_i + {29'd0, pre};
    info_o.nlen = span_len_i - {29'd0, pre};
  end

endmodule

// ===== rtl/core/annexb_to_length_prefixed_sample.sv =====
// Converts one H.264 access unit, given as a run of NAL span descriptors on the
// slave stream, into AVCC copy commands on the master stream.
// Slave item: one span descriptor; tlast marks the last span of the unit, tuser
// marks an empty unit. Master item: a copy command (tlast low) or the unit
// summary (tlast high) carrying status, total size, key frame and SPS/PPS.
// Each span is first registered, then checked, and a VCL span is written into
// the span memory. Spans without tlast give no item.
// After the last span a decide state picks the status; a built unit then walks
// the span memory with a synchronous read and an output load per copy command,
// followed by the summary. Any other status gives the summary alone.
// The output register holds a result while the receiver stalls; the walk waits
// on it, and the next span is taken while the summary is still waiting.
// Reset clears the sequencer and the unit counters; the span memory needs no
// clearing since only entries written in the current unit are read.
module annexb_to_length_prefixed_sample
  import ab2lp_pkg::*;
#(
  parameter int unsigned MAX_SPANS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // span_offset, span_len, head_bytes, au_size, out_capacity, pts, generation
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  // empty_unit
  input  logic             s_axis_tuser_i,
  input  logic             s_axis_tlast_i,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // status, byte_position, source_offset, copy_len, key_frame, sps_start,
  // sps_len, pps_start, pps_len, pts_out, generation_out, zero pad
  output logic [OUT_W-1:0] m_axis_tdata_o,
  output logic             m_axis_tlast_o,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i
);

  localparam int unsigned SCW = $clog2(MAX_SPANS + 2);
  localparam int unsigned CW  = $clog2(MAX_SPANS + 1);
  localparam int unsigned AW  = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;

  fsm_e        state_q, state_d;
  span_item_t  in_q, in_d;
  logic        empty_q, empty_d, last_q, last_d;
  logic [SCW-1:0] span_cnt_q, span_cnt_d, cnt_n;
  logic [CW-1:0]  vcl_cnt_q, vcl_cnt_d, idx_q, idx_d;
  logic [32:0] total_q, total_d, pos_q, pos_d;
  logic [33:0] total_sum;
  logic        err_q, err_d, key_q, key_d;
  logic [31:0] sps_off_q, sps_off_d, sps_len_q, sps_len_d;
  logic [31:0] pps_off_q, pps_off_d, pps_len_q, pps_len_d;
  status_e     status_q, status_d;
  span_info_t  info;

  logic        mem_we;
  logic [63:0] span_mem [MAX_SPANS];
  logic [63:0] rd_q;

  logic        out_valid_q, out_last_q, out_load, out_last_d, out_free;
  result_t     out_q, out_d;

  // Parse the registered span
  ab2lp_span_parse u_parse (
    .span_offset_i (in_q.span_offset),
    .span_len_i    (in_q.span_len),
    .head_bytes_i  (in_q.head_bytes),
    .au_size_i     (in_q.au_size),
    .info_o        (info)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign cnt_n           = (span_cnt_q <= SCW'(MAX_SPANS)) ? span_cnt_q + 1'b1 : span_cnt_q;
  assign total_sum       = {1'b0, total_q} + {2'b00, info.nlen} + {1'b0, LEN_WORD};

  // Sequence span intake, status decision and the copy walk
  always_comb begin
    state_d    = state_q;
    in_d       = in_q;
    empty_d    = empty_q;
    last_d     = last_q;
    span_cnt_d = span_cnt_q;
    vcl_cnt_d  = vcl_cnt_q;
    idx_d      = idx_q;
    total_d    = total_q;
    pos_d      = pos_q;
    err_d      = err_q;
    key_d      = key_q;
    sps_off_d  = sps_off_q;
    sps_len_d  = sps_len_q;
    pps_off_d  = pps_off_q;
    pps_len_d  = pps_len_q;
    status_d   = status_q;
    mem_we     = 1'b0;
    out_load   = 1'b0;
    out_last_d = 1'b0;
    out_d      = '0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          in_d    = span_item_t'(s_axis_tdata_i);
          empty_d = s_axis_tuser_i;
          last_d  = s_axis_tlast_i;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (empty_q) begin
          status_d = STAT_INVALID;
          state_d  = S_SUM;
        end else begin
          span_cnt_d = cnt_n;
          if (cnt_n <= SCW'(MAX_SPANS) && !err_q) begin
            if (info.bad) begin
              err_d = 1'b1;
            end else if (info.vcl) begin
              if (vcl_cnt_q < CW'(MAX_SPANS)) begin
                mem_we    = 1'b1;
                vcl_cnt_d = vcl_cnt_q + 1'b1;
              end
              total_d = (total_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : total_sum[32:0];
              if (info.idr) key_d = 1'b1;
            end else if (info.sps && sps_len_q == 32'd0) begin
              sps_off_d = info.poff;
              sps_len_d = info.nlen;
            end else if (info.pps && pps_len_q == 32'd0) begin
              pps_off_d = info.poff;
              pps_len_d = info.nlen;
            end
          end
          state_d = last_q ? S_DECIDE : S_IDLE;
        end
      end
      S_DECIDE: begin
        if (span_cnt_q > SCW'(MAX_SPANS))           status_d = STAT_INVALID;
        else if (err_q)                             status_d = STAT_PROTOCOL;
        else if (vcl_cnt_q == '0)                   status_d = STAT_NO_VCL;
        else if (total_q > {1'b0, in_q.out_capacity}) status_d = STAT_NO_SPACE;
        else                                        status_d = STAT_BUILT;
        pos_d   = '0;
        idx_d   = '0;
        state_d = (status_d == STAT_BUILT) ? S_READ : S_SUM;
      end
      S_READ: begin
        state_d = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_d.status        = STAT_BUILT;
          out_d.byte_position = pos_q;
          out_d.source_offset = rd_q[31:0];
          out_d.copy_len      = rd_q[63:32];
          pos_d               = pos_q + {1'b0, rd_q[63:32]} + LEN_WORD;
          idx_d               = idx_q + 1'b1;
          state_d             = (idx_d == vcl_cnt_q) ? S_SUM : S_READ;
        end
      end
      S_SUM: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_last_d   = 1'b1;
          out_d.status = status_q;
          if (status_q == STAT_BUILT) begin
            out_d.byte_position = pos_q;
            out_d.key_frame     = key_q;
          end
          if (status_q == STAT_BUILT || status_q == STAT_NO_VCL) begin
            out_d.sps_start      = sps_off_q;
            out_d.sps_len        = sps_len_q;
            out_d.pps_start      = pps_off_q;
            out_d.pps_len        = pps_len_q;
            out_d.pts_out        = in_q.pts;
            out_d.generation_out = in_q.generation;
          end
          // clear the unit
          span_cnt_d = '0;
          vcl_cnt_d  = '0;
          total_d    = '0;
          err_d      = 1'b0;
          key_d      = 1'b0;
          sps_off_d  = '0;
          sps_len_d  = '0;
          pps_off_d  = '0;
          pps_len_d  = '0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the sequencer and unit state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      empty_q    <= 1'b0;
      last_q     <= 1'b0;
      span_cnt_q <= '0;
      vcl_cnt_q  <= '0;
      idx_q      <= '0;
      total_q    <= '0;
      pos_q      <= '0;
      err_q      <= 1'b0;
      key_q      <= 1'b0;
      sps_off_q  <= '0;
      sps_len_q  <= '0;
      pps_off_q  <= '0;
      pps_len_q  <= '0;
      status_q   <= STAT_BUILT;
    end else begin
      state_q    <= state_d;
      empty_q    <= empty_d;
      last_q     <= last_d;
      span_cnt_q <= span_cnt_d;
      vcl_cnt_q  <= vcl_cnt_d;
      idx_q      <= idx_d;
      total_q    <= total_d;
      pos_q      <= pos_d;
      err_q      <= err_d;
      key_q      <= key_d;
      sps_off_q  <= sps_off_d;
      sps_len_q  <= sps_len_d;
      pps_off_q  <= pps_off_d;
      pps_len_q  <= pps_len_d;
      status_q   <= status_d;
    end
  end

  // Capture the span descriptor
  always_ff @(posedge clk_i) begin
    in_q <= in_d;
  end

  // Store VCL entries as {length, offset}; read one per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      span_mem[vcl_cnt_q[AW-1:0]] <= {info.nlen, info.poff};
    end
    rd_q <= span_mem[idx_q[AW-1:0]];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
      out_last_q  <= out_last_d;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = OUT_W'(out_q);

  // The walk only reads entries written in this unit
  a_push_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH) |-> (idx_q < vcl_cnt_q))
    else $error("copy walk past stored VCL entries");

  // VCL entries never outnumber spans
  a_vcl_le_spans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SCW'(vcl_cnt_q) <= span_cnt_q)
    else $error("VCL count exceeds span count");

  // A memory read is always followed by the push that consumes it
  a_read_then_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> (state_q == S_PUSH))
    else $error("read data not consumed");

  // Writes stay inside the span memory
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (vcl_cnt_q < CW'(MAX_SPANS)))
    else $error("span memory write out of range");

  // A summary leaves the unit cleared
  a_sum_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last_d) |=> (span_cnt_q == '0 && vcl_cnt_q == '0 && !err_q))
    else $error("unit state not cleared after summary");

endmodule
